### rtl/core/tdl_pkg.sv
package tdl_pkg;

	// default directory size
	localparam int DIRECTORY_DEPTH_DEF = 4096;

	// field widths
	localparam int ZOOM_W   = 5;
	localparam int COORD_W  = 31;
	localparam int ID_W     = 64;
	localparam int TILE_W   = 63;
	localparam int RUN_W    = 8;
	localparam int BYTE_W   = 32;
	localparam int CODE_W   = 33;
	localparam int CFG_IX_W = 2;
	localparam int CFG_D_W  = 5;

	// run saturation limit
	localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

	// request actions
	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_LOCATE = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_TILE = 2'd1;
	localparam logic [1:0] ST_LEAF = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_ZOOM_LO   = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_ZOOM_HI   = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_LEAF_MODE = 2'd2;

	// one stored directory entry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [RUN_W-1:0]  run;
		logic [BYTE_W-1:0] offset;
		logic [BYTE_W-1:0] length;
	} dir_entry_t;

	// request to the hilbert walker
	typedef struct packed {
		logic               start;
		logic [ZOOM_W-1:0]  zoom;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} hil_req_t;

	// level base (4^z-1)/3: ones at the even bit positions below 2z
	function automatic logic [TILE_W-2:0] level_base(input logic [ZOOM_W-1:0] z);
		logic [TILE_W-2:0] b;
		b = '0;
		for (int i = 0; i < COORD_W; i++) begin
			b[2*i] = (ZOOM_W'(i) < z);
		end
		return b;
	endfunction

endpackage

### rtl/core/tdl_if.sv
// request channel
interface tdl_req_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     action;
	logic [tdl_pkg::ID_W-1:0]       entry_id_delta;
	logic [tdl_pkg::BYTE_W-1:0]     entry_run;
	logic [tdl_pkg::CODE_W-1:0]     entry_offset_code;
	logic [tdl_pkg::BYTE_W-1:0]     entry_length;
	logic [tdl_pkg::ZOOM_W-1:0]     zoom;
	logic [tdl_pkg::COORD_W-1:0]    tile_x;
	logic [tdl_pkg::COORD_W-1:0]    tile_y;

	modport source (
		output valid, action, entry_id_delta, entry_run, entry_offset_code,
		       entry_length, zoom, tile_x, tile_y,
		input  ready
	);
	modport sink (
		input  valid, action, entry_id_delta, entry_run, entry_offset_code,
		       entry_length, zoom, tile_x, tile_y,
		output ready
	);
endinterface

// result channel
interface tdl_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [tdl_pkg::TILE_W-1:0]     tile_id;
	logic [tdl_pkg::BYTE_W-1:0]     byte_offset;
	logic [tdl_pkg::BYTE_W-1:0]     byte_length;

	modport source (
		output valid, status, tile_id, byte_offset, byte_length,
		input  ready
	);
	modport sink (
		input  valid, status, tile_id, byte_offset, byte_length,
		output ready
	);
endinterface

### rtl/core/tile_directory_locator.sv
// Tile directory locator.
// Request channel (req): action 0 appends a directory entry, 1 locates a
// tile, 2 clears the directory; other codes are dropped. Only a locate
// gives a result, on the result channel (rsp).
// Configuration: cfg_we/cfg_index/cfg_data write the lowest and highest
// zoom held and leaf_mode; write them only while no locate is in flight.
// Append, clear and dropped codes are taken back to back. A locate runs
// through the Hilbert walker (one curve level per cycle, the base add and
// the done flag), then the binary search over the n loaded entries,
// ceil(log2(n+1)) steps, each of which waits on the registered directory
// read, then closes the search and does the run check. A zoom out of range
// skips the search.
// Requests are taken only between locates. The result sits in an output
// register; a stalled receiver holds it there while further appends are
// accepted, and a following locate waits at its run check until the
// register is free.
// Reset empties the directory (no clearing pass, the fill count is zeroed)
// and sets the zoom limits to 0 and 31 and leaf_mode to 0.
module tile_directory_locator #(
	parameter int DIRECTORY_DEPTH = tdl_pkg::DIRECTORY_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tdl_req_if.sink                        req,
	tdl_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [tdl_pkg::CFG_IX_W-1:0]   cfg_index,
	input  logic [tdl_pkg::CFG_D_W-1:0]    cfg_data
);
	import tdl_pkg::*;

	localparam int AW = (DIRECTORY_DEPTH > 1) ? $clog2(DIRECTORY_DEPTH) : 1;
	localparam int CW = $clog2(DIRECTORY_DEPTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_HILB, S_ADDR, S_CMP, S_CHECK} state_t;

	state_t              state_q;
	logic [ZOOM_W-1:0]   zoom_lo_q, zoom_hi_q, z_q;
	logic                leaf_mode_q;
	logic [CW-1:0]       loaded_q, low_q, high_q, mid_q;
	logic [ID_W-1:0]     running_id_q;
	logic [BYTE_W-1:0]   prev_end_q;
	logic                hit_q;
	dir_entry_t          ent_q;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [TILE_W-1:0]   out_tile_q;
	logic [BYTE_W-1:0]   out_offset_q, out_length_q;

	logic                accept, do_append, out_free;
	logic [BYTE_W-1:0]   new_offset;
	logic [ID_W-1:0]     new_id;
	dir_entry_t          wr_entry, rd_entry;
	hil_req_t            hil_req;
	logic                hil_done;
	logic [TILE_W-1:0]   want;
	logic [CW-1:0]       mid;
	logic [ID_W-1:0]     diff;
	logic [RUN_W-1:0]    span;
	logic [1:0]          status_c;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign do_append = accept && (req.action == ACT_APPEND) &&
	                   (loaded_q < CW'(DIRECTORY_DEPTH));
	assign out_free  = !out_valid_q || rsp.ready;

	// append: running id, saturated run and resolved offset
	always_comb begin
		new_id = running_id_q + req.entry_id_delta;
		if (req.entry_offset_code == '0) begin
			new_offset = (loaded_q == '0) ? '0 : prev_end_q;
		end else begin
			new_offset = req.entry_offset_code[BYTE_W-1:0] - BYTE_W'(1);
		end
		wr_entry.id     = new_id;
		wr_entry.run    = (req.entry_run[BYTE_W-1:RUN_W] != '0) ? RUN_MAX :
		                  req.entry_run[RUN_W-1:0];
		wr_entry.offset = new_offset;
		wr_entry.length = req.entry_length;
	end

	// hilbert walker start
	always_comb begin
		hil_req.start = accept && (req.action == ACT_LOCATE);
		hil_req.zoom  = req.zoom;
		hil_req.x     = req.tile_x;
		hil_req.y     = req.tile_y;
	end

	tdl_hilbert u_hilbert (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hil_req),
		.done    (hil_done),
		.tile_id (want)
	);

	// search midpoint
	assign mid = low_q + ((high_q - low_q) >> 1);

	tdl_dir_mem #(
		.DEPTH (DIRECTORY_DEPTH),
		.AW    (AW)
	) u_dir_mem (
		.clk     (clk),
		.wr_en   (do_append),
		.wr_addr (loaded_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (mid[AW-1:0]),
		.rd_data (rd_entry)
	);

	// run check on the picked entry
	always_comb begin
		diff = {1'b0, want} - ent_q.id;
		span = (ent_q.run == '0) ? RUN_W'(1) : ent_q.run;
		if (!hit_q) begin
			status_c = ST_NONE;
		end else if (leaf_mode_q && ent_q.run == '0) begin
			status_c = ST_LEAF;
		end else if (diff[ID_W-1:RUN_W] == '0 && diff[RUN_W-1:0] < span) begin
			status_c = ST_TILE;
		end else begin
			status_c = ST_NONE;
		end
	end

	// sequencer, directory bookkeeping, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			zoom_lo_q    <= '0;
			zoom_hi_q    <= '1;
			leaf_mode_q  <= 1'b0;
			z_q          <= '0;
			loaded_q     <= '0;
			running_id_q <= '0;
			prev_end_q   <= '0;
			low_q        <= '0;
			high_q       <= '0;
			mid_q        <= '0;
			hit_q        <= 1'b0;
			ent_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_NONE;
			out_tile_q   <= '0;
			out_offset_q <= '0;
			out_length_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ZOOM_LO:   zoom_lo_q   <= cfg_data;
					CFG_ZOOM_HI:   zoom_hi_q   <= cfg_data;
					CFG_LEAF_MODE: leaf_mode_q <= cfg_data[0];
					default: ;
				endcase
			end

			// result valid: set by the run check, cleared by a transfer
			if (state_q == S_CHECK && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.action)
							ACT_APPEND: begin
								if (do_append) begin
									running_id_q <= new_id;
									prev_end_q   <= new_offset + req.entry_length;
									loaded_q     <= loaded_q + CW'(1);
								end
							end
							ACT_LOCATE: begin
								z_q     <= req.zoom;
								state_q <= S_HILB;
							end
							ACT_CLEAR: begin
								loaded_q     <= '0;
								running_id_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_HILB: begin
					if (hil_done) begin
						hit_q  <= 1'b0;
						low_q  <= '0;
						high_q <= loaded_q;
						if (z_q < zoom_lo_q || z_q > zoom_hi_q) begin
							state_q <= S_CHECK;
						end else begin
							state_q <= S_ADDR;
						end
					end
				end
				S_ADDR: begin
					if (low_q < high_q) begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CMP: begin
					if (rd_entry.id <= {1'b0, want}) begin
						hit_q <= 1'b1;
						ent_q <= rd_entry;
						low_q <= mid_q + CW'(1);
					end else begin
						high_q <= mid_q;
					end
					state_q <= S_ADDR;
				end
				S_CHECK: begin
					if (out_free) begin
						out_status_q <= status_c;
						out_tile_q   <= want;
						out_offset_q <= (status_c == ST_NONE) ? '0 : ent_q.offset;
						out_length_q <= (status_c == ST_NONE) ? '0 : ent_q.length;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.tile_id     = out_tile_q;
	assign rsp.byte_offset = out_offset_q;
	assign rsp.byte_length = out_length_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CW'(DIRECTORY_DEPTH))
		else $error("directory fill count beyond depth");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR || state_q == S_CMP) |-> (low_q <= high_q && high_q <= loaded_q))
		else $error("search window out of order");

	a_walker_done: assert property (@(posedge clk) disable iff (!arst_n)
		hil_done |-> state_q == S_HILB)
		else $error("hilbert walker finished outside a locate");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_NONE) |-> (rsp.byte_offset == '0 && rsp.byte_length == '0))
		else $error("miss result carries a location");

	a_result_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_CHECK)
		else $error("result loaded outside the run check");
`endif

endmodule

### rtl/core/tdl_hilbert.sv
module tdl_hilbert (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tdl_pkg::hil_req_t           req,
	output logic                        done,
	output logic [tdl_pkg::TILE_W-1:0]  tile_id
);
	import tdl_pkg::*;

	typedef enum logic [1:0] {H_IDLE, H_WALK, H_ADD} hstate_t;

	hstate_t             state_q;
	logic [COORD_W-1:0]  cx_q, cy_q;
	logic [ZOOM_W-1:0]   k_q;
	logic [ZOOM_W-1:0]   z_q;
	logic [TILE_W-2:0]   sum_q;
	logic [TILE_W-1:0]   tile_id_q;
	logic                done_q;

	logic                bx, by;
	logic [COORD_W-1:0]  fx, fy;
	logic [TILE_W-2:0]   digit;

	// one curve level per cycle, most significant level first
	always_comb begin
		bx = cx_q[k_q];
		by = cy_q[k_q];
		fx = bx ? ~cx_q : cx_q;
		fy = bx ? ~cy_q : cy_q;
		digit = {{(TILE_W-3){1'b0}}, bx, bx ^ by} << {k_q, 1'b0};
	end

	// walker sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= H_IDLE;
			cx_q      <= '0;
			cy_q      <= '0;
			k_q       <= '0;
			z_q       <= '0;
			sum_q     <= '0;
			tile_id_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (req.start) begin
						cx_q  <= req.x;
						cy_q  <= req.y;
						z_q   <= req.zoom;
						k_q   <= req.zoom - ZOOM_W'(1);
						sum_q <= '0;
						state_q <= (req.zoom == '0) ? H_ADD : H_WALK;
					end
				end
				H_WALK: begin
					sum_q <= sum_q | digit;
					if (!by) begin
						cx_q <= fy;
						cy_q <= fx;
					end
					if (k_q == '0) begin
						state_q <= H_ADD;
					end else begin
						k_q <= k_q - ZOOM_W'(1);
					end
				end
				H_ADD: begin
					tile_id_q <= {1'b0, sum_q} + {1'b0, level_base(z_q)};
					done_q    <= 1'b1;
					state_q   <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign tile_id = tile_id_q;

endmodule

### rtl/core/tdl_dir_mem.sv
module tdl_dir_mem #(
	parameter int DEPTH = tdl_pkg::DIRECTORY_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  tdl_pkg::dir_entry_t   wr_data,
	input  logic [AW-1:0]         rd_addr,
	output tdl_pkg::dir_entry_t   rd_data
);
	import tdl_pkg::*;

	logic [ID_W-1:0]   ids_mem     [DEPTH];
	logic [RUN_W-1:0]  runs_mem    [DEPTH];
	logic [BYTE_W-1:0] offsets_mem [DEPTH];
	logic [BYTE_W-1:0] lengths_mem [DEPTH];
	dir_entry_t        rd_q;

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ids_mem[wr_addr]     <= wr_data.id;
			runs_mem[wr_addr]    <= wr_data.run;
			offsets_mem[wr_addr] <= wr_data.offset;
			lengths_mem[wr_addr] <= wr_data.length;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_q.id     <= ids_mem[rd_addr];
		rd_q.run    <= runs_mem[rd_addr];
		rd_q.offset <= offsets_mem[rd_addr];
		rd_q.length <= lengths_mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule
